/* rtl/sadf_pkg.sv */
// Shared types, constants and helpers for the scan address dedup filter.
// Used by sadf_cell, sadf_chain and scan_address_dedup_filter_core.
package sadf_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 48;
   localparam int CNT_W       = 16;

   localparam logic [CNT_W-1:0]   CNT_MAX           = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0]   MAX_RECORDS_RESET = 16'd128;
   localparam logic [COUNT_W-1:0] DEPTH_COUNT       = TABLE_DEPTH[COUNT_W-1:0];
   localparam logic [COUNT_W-1:0] COUNT_ONE         = {{(COUNT_W-1){1'b0}}, 1'b1};

   // Action codes.
   localparam logic [1:0] ACT_ADVERT  = 2'd0;
   localparam logic [1:0] ACT_VERDICT = 2'd1;
   localparam logic [1:0] ACT_CLEAR   = 2'd2;

   // Verdict codes.
   localparam logic [1:0] VERD_ACCEPTED = 2'd0;
   localparam logic [1:0] VERD_REJECTED = 2'd1;
   localparam logic [1:0] VERD_DROPPED  = 2'd2;

   // Outcome codes.
   localparam logic [2:0] OUT_DUP   = 3'd0;
   localparam logic [2:0] OUT_FULL  = 3'd1;
   localparam logic [2:0] OUT_LIMIT = 3'd2;
   localparam logic [2:0] OUT_FWD   = 3'd3;
   localparam logic [2:0] OUT_BOOK  = 3'd4;

   typedef struct packed {
      logic [1:0]        action;
      logic [ADDR_W-1:0] device_address;
      logic [1:0]        verdict;
   } req_type;

   typedef struct packed {
      logic [2:0]       outcome;
      logic [CNT_W-1:0] reported_count;
      logic [CNT_W-1:0] read_count;
      logic [CNT_W-1:0] accepted_count;
      logic [CNT_W-1:0] rejected_count;
      logic [CNT_W-1:0] dropped_count;
   } rsp_type;

   // Search token that walks down the row of cells.
   typedef struct packed {
      logic              valid;
      logic              hit;
      logic [ADDR_W-1:0] key;
   } token_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] r;
      r = (c == CNT_MAX) ? c : c + {{(CNT_W-1){1'b0}}, 1'b1};
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] to_count(input int unsigned v);
      return v[COUNT_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] to_idx(input int unsigned v);
      return v[IDX_W-1:0];
   endfunction

endpackage

/* rtl/sadf_cell.sv */
// One table cell: holds one stored address and compares it with the passing token.
// Depends on sadf_pkg for the token type and widths.
module sadf_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  sadf_pkg::token_type             up_tok,
   output sadf_pkg::token_type             down_tok,
   input  logic                            live,
   input  logic                            wr_en,
   input  logic [sadf_pkg::ADDR_W-1:0]     wr_addr
);

   logic [sadf_pkg::ADDR_W-1:0] entry_ff;
   sadf_pkg::token_type         tok_ff;
   sadf_pkg::token_type         tok_in;

   always_comb begin
      tok_in     = up_tok;
      tok_in.hit = up_tok.hit | (live & (entry_ff == up_tok.key));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.hit <= tok_in.hit;
      tok_ff.key <= tok_in.key;
   end

   assign down_tok = tok_ff;

endmodule

/* rtl/sadf_chain.sv */
// Row of TABLE_DEPTH cells that forms the address table and its search path.
// Depends on sadf_pkg and sadf_cell.
module sadf_chain (
   input  logic                             clock,
   input  logic                             reset,
   input  sadf_pkg::token_type              head_tok,
   output sadf_pkg::token_type              tail_tok,
   input  logic [sadf_pkg::COUNT_W-1:0]     entry_count,
   input  logic                             wr_en,
   input  logic [sadf_pkg::IDX_W-1:0]       wr_idx,
   input  logic [sadf_pkg::ADDR_W-1:0]      wr_addr
);

   sadf_pkg::token_type tok [0:sadf_pkg::TABLE_DEPTH];

   assign tok[0]   = head_tok;
   assign tail_tok = tok[sadf_pkg::TABLE_DEPTH];

   for (genvar g = 0; g < sadf_pkg::TABLE_DEPTH; g++) begin : g_cell
      logic live;
      logic cell_wr;

      // Only entries below the fill count hold addresses of this scan.
      assign live    = sadf_pkg::to_count(g) < entry_count;
      assign cell_wr = wr_en & (wr_idx == sadf_pkg::to_idx(g));

      sadf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_tok   (tok[g]),
         .down_tok (tok[g+1]),
         .live     (live),
         .wr_en    (cell_wr),
         .wr_addr  (wr_addr)
      );
   end

endmodule

/* rtl/scan_address_dedup_filter_core.sv */
// Top level of the scan address dedup filter: control, counters and result register.
// Depends on sadf_pkg and sadf_chain.

// An advertisement beat's address walks the row of TABLE_DEPTH cells one cell per cycle,
// each cell comparing it with its stored entry. The last cell's hit flag is registered
// and then committed once the result register is free. Verdict, clear and unused action
// beats are answered in the cycle after acceptance. One beat is in work at a time; a new
// beat is taken once the result register is free or is being emptied.
module scan_address_dedup_filter_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sadf_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output sadf_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [sadf_pkg::CNT_W-1:0]     csr_wr_data
);

   sadf_pkg::state_type state_ff, state_in;

   logic [sadf_pkg::COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic [sadf_pkg::CNT_W-1:0]   reported_ff, reported_in;
   logic [sadf_pkg::CNT_W-1:0]   read_ff, read_in;
   logic [sadf_pkg::CNT_W-1:0]   accepted_ff, accepted_in;
   logic [sadf_pkg::CNT_W-1:0]   rejected_ff, rejected_in;
   logic [sadf_pkg::CNT_W-1:0]   dropped_ff, dropped_in;
   logic [sadf_pkg::CNT_W-1:0]   max_records_ff;

   sadf_pkg::token_type fin_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   sadf_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   sadf_pkg::token_type head_tok, tail_tok;
   logic                out_free;
   logic                accept;
   logic                start_search;
   logic                book_go;
   logic                commit_go;
   logic                wr_en;
   logic [2:0]          outcome;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // FSM outputs.
   always_comb begin
      req_stall    = 1'b1;
      commit_go    = 1'b0;
      unique case (state_ff)
         sadf_pkg::ST_IDLE: begin
            req_stall = ~out_free;
         end
         sadf_pkg::ST_SEARCH: begin
            req_stall = 1'b1;
         end
         sadf_pkg::ST_FINISH: begin
            commit_go = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      accept       = req_valid & ~req_stall;
      start_search = accept & (req_data.action == sadf_pkg::ACT_ADVERT);
      book_go      = accept & (req_data.action != sadf_pkg::ACT_ADVERT);
   end

   // FSM next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sadf_pkg::ST_IDLE: begin
            if (start_search) begin
               state_in = sadf_pkg::ST_SEARCH;
            end
         end
         sadf_pkg::ST_SEARCH: begin
            if (tail_tok.valid) begin
               state_in = sadf_pkg::ST_FINISH;
            end
         end
         sadf_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = sadf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sadf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      head_tok.valid = start_search;
      head_tok.hit   = 1'b0;
      head_tok.key   = req_data.device_address;
   end

   sadf_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .head_tok    (head_tok),
      .tail_tok    (tail_tok),
      .entry_count (entry_count_ff),
      .wr_en       (wr_en),
      .wr_idx      (entry_count_ff[sadf_pkg::IDX_W-1:0]),
      .wr_addr     (fin_ff.key)
   );

   // Counter and table updates for a committed advertisement or a bookkeeping beat.
   always_comb begin
      entry_count_in = entry_count_ff;
      reported_in    = reported_ff;
      read_in        = read_ff;
      accepted_in    = accepted_ff;
      rejected_in    = rejected_ff;
      dropped_in     = dropped_ff;
      wr_en          = 1'b0;
      outcome        = sadf_pkg::OUT_BOOK;
      if (commit_go) begin
         priority if (fin_ff.hit) begin
            outcome = sadf_pkg::OUT_DUP;
         end else if (entry_count_ff == sadf_pkg::DEPTH_COUNT) begin
            outcome    = sadf_pkg::OUT_FULL;
            dropped_in = sadf_pkg::sat_inc(dropped_ff);
         end else begin
            wr_en          = 1'b1;
            entry_count_in = entry_count_ff + sadf_pkg::COUNT_ONE;
            reported_in    = sadf_pkg::sat_inc(reported_ff);
            if (read_ff >= max_records_ff) begin
               outcome    = sadf_pkg::OUT_LIMIT;
               dropped_in = sadf_pkg::sat_inc(dropped_ff);
            end else begin
               outcome = sadf_pkg::OUT_FWD;
               read_in = sadf_pkg::sat_inc(read_ff);
            end
         end
      end else if (book_go) begin
         if (req_data.action == sadf_pkg::ACT_VERDICT) begin
            unique case (req_data.verdict)
               sadf_pkg::VERD_ACCEPTED: accepted_in = sadf_pkg::sat_inc(accepted_ff);
               sadf_pkg::VERD_REJECTED: rejected_in = sadf_pkg::sat_inc(rejected_ff);
               sadf_pkg::VERD_DROPPED:  dropped_in  = sadf_pkg::sat_inc(dropped_ff);
               default: begin
               end
            endcase
         end else if (req_data.action == sadf_pkg::ACT_CLEAR) begin
            entry_count_in = '0;
            reported_in    = '0;
            read_in        = '0;
            accepted_in    = '0;
            rejected_in    = '0;
            dropped_in     = '0;
         end
      end
   end

   always_comb begin
      rsp_data_in.outcome        = outcome;
      rsp_data_in.reported_count = reported_in;
      rsp_data_in.read_count     = read_in;
      rsp_data_in.accepted_count = accepted_in;
      rsp_data_in.rejected_count = rejected_in;
      rsp_data_in.dropped_count  = dropped_in;
      if (commit_go | book_go) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sadf_pkg::ST_IDLE;
         entry_count_ff <= '0;
         reported_ff    <= '0;
         read_ff        <= '0;
         accepted_ff    <= '0;
         rejected_ff    <= '0;
         dropped_ff     <= '0;
         max_records_ff <= sadf_pkg::MAX_RECORDS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         reported_ff    <= reported_in;
         read_ff        <= read_in;
         accepted_ff    <= accepted_in;
         rejected_ff    <= rejected_in;
         dropped_ff     <= dropped_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            max_records_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == sadf_pkg::ST_SEARCH) && tail_tok.valid) begin
         fin_ff <= tail_tok;
      end
      if (commit_go | book_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
